@@ design/rsgi_pkg.sv @@
// Shared constants, types and the exp(-u) sample table of the Gaussian Riemann sum unit.
package rsgi_pkg;

  localparam int unsigned INDEX_BITS      = 32;
  localparam int unsigned EXP_TABLE_DEPTH = 1024;
  localparam int unsigned EXP_ADDR_BITS   = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DIV_BITS        = 34;
  localparam int unsigned DIV_CNT_BITS    = $clog2(DIV_BITS);

  localparam logic [31:0] IDX_MASK = (INDEX_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic signed [34:0] ZONE_EDGE = 35'sd67108864;
  localparam logic signed [49:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SUM_MIN = -SUM_MAX - 50'sd1;

  localparam logic [1:0] REG_LOWER = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_STEP,
    ST_MUL0,
    ST_MUL1,
    ST_CHK,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_MULX,
    ST_LOADX,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
  } point_req_t;

  typedef struct packed {
    logic busy;
    logic sat;
  } pipe_status_t;

  typedef logic [31:0] exp_table_t [EXP_TABLE_DEPTH];

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic exp_table_t build_exp_table();
    exp_table_t  t;
    logic [63:0] d;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] s;
    d = ((64'h8000_0000_0000_0000 / EXP_TABLE_DEPTH) * 64'd2)
      + (((64'h8000_0000_0000_0000 % EXP_TABLE_DEPTH) * 64'd2) / EXP_TABLE_DEPTH);
    term = 64'd1 << 60;
    r    = 64'd1 << 60;
    e    = 64'd1 << 60;
    for (int k = 1; k <= 24; k++) begin
      term = mul_q60(term, d) / 64'(k);
      if (k % 2 == 1) r = r - term;
      else r = r + term;
    end
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      s    = (e + (64'd1 << 28)) >> 29;
      t[k] = s[31:0];
      e    = mul_q60(e, r);
    end
    return t;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ design/rsgi_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module rsgi_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rsgi_pkg::DIV_BITS-1:0] dividend_i,
  input  logic [31:0]                   divisor_i,
  output logic                          done_o,
  output logic [rsgi_pkg::DIV_BITS-1:0] quotient_o
);

  logic                              run_q, run_d;
  logic                              done_q, done_d;
  logic [rsgi_pkg::DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [rsgi_pkg::DIV_BITS-1:0]     quo_q, quo_d;
  logic [31:0]                       rem_q, rem_d;
  logic [31:0]                       dvs_q, dvs_d;
  logic [32:0]                       trial;
  logic                              fits;

  always_comb begin
    trial = {rem_q, quo_q[rsgi_pkg::DIV_BITS-1]};
    fits  = trial >= {1'b0, dvs_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (run_q) begin
      rem_d = fits ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quo_d = {quo_q[rsgi_pkg::DIV_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rsgi_pkg::DIV_CNT_BITS'(rsgi_pkg::DIV_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ design/rsgi_exp_rom.sv @@
// Dual-port registered read of the exp(-u) sample table.
module rsgi_exp_rom (
  input  logic                               clk_i,
  input  logic [rsgi_pkg::EXP_ADDR_BITS-1:0] addr_a_i,
  input  logic [rsgi_pkg::EXP_ADDR_BITS-1:0] addr_b_i,
  output logic [31:0]                        data_a_o,
  output logic [31:0]                        data_b_o
);

  logic [31:0] data_a_q;
  logic [31:0] data_b_q;

  always_ff @(posedge clk_i) begin
    data_a_q <= rsgi_pkg::EXP_TABLE[addr_a_i];
    data_b_q <= rsgi_pkg::EXP_TABLE[addr_b_i];
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

@@ design/rsgi_point_pipe.sv @@
// Per-point pipeline: square, table lookup, interpolation, step scaling and accumulation.
module rsgi_point_pipe (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  rsgi_pkg::point_req_t   req_i,
  input  logic [31:0]            step_mag_i,
  input  logic                   step_neg_i,
  output rsgi_pkg::pipe_status_t status_o,
  output logic signed [47:0]     sum_o
);

  localparam int unsigned A = rsgi_pkg::EXP_ADDR_BITS;

  logic                   v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [31:0]            ax;
  logic [51:0]            u1_q;
  logic [A-1:0]           idx;
  logic [A-1:0]           idx_next;
  logic [31:0]            frac;
  logic [31:0]            frac2_q;
  logic                   last2_q;
  logic [31:0]            ra, rb;
  logic [31:0]            b_eff;
  logic [31:0]            a3_q;
  logic [63:0]            prod3_q;
  logic [31:0]            f4_q;
  logic [63:0]            m5_q;
  logic signed [49:0]     term;
  logic signed [49:0]     next_sum;
  logic signed [47:0]     sum_q, sum_d;
  logic                   sat_q, sat_d;

  assign ax       = req_i.x[31] ? 32'(-req_i.x) : req_i.x;
  assign idx      = u1_q[51 -: A];
  assign idx_next = idx + 1'b1;
  assign frac     = {u1_q[51-A:20], {A{1'b0}}};

  rsgi_exp_rom u_rom (
    .clk_i    (clk_i),
    .addr_a_i (idx),
    .addr_b_i (idx_next),
    .data_a_o (ra),
    .data_b_o (rb)
  );

  always_comb begin
    b_eff = last2_q ? 32'd0 : rb;
    if (ra < b_eff) b_eff = ra;
  end

  always_ff @(posedge clk_i) begin
    u1_q    <= {26'd0, ax[25:0]} * {26'd0, ax[25:0]};
    frac2_q <= frac;
    last2_q <= (idx == A'(rsgi_pkg::EXP_TABLE_DEPTH - 1));
    a3_q    <= ra;
    prod3_q <= {32'd0, 32'(ra - b_eff)} * {32'd0, frac2_q};
    f4_q    <= a3_q - prod3_q[63:32];
    m5_q    <= {32'd0, f4_q} * {32'd0, step_mag_i};
  end

  always_comb begin
    term     = step_neg_i ? -$signed({1'b0, m5_q[63:15]}) : $signed({1'b0, m5_q[63:15]});
    next_sum = {{2{sum_q[47]}}, sum_q} + term;
    sum_d    = sum_q;
    sat_d    = sat_q;
    if (clear_i) begin
      sum_d = '0;
      sat_d = 1'b0;
    end else if (v5_q) begin
      if (next_sum > rsgi_pkg::SUM_MAX) begin
        sum_d = rsgi_pkg::SUM_MAX[47:0];
        sat_d = 1'b1;
      end else if (next_sum < rsgi_pkg::SUM_MIN) begin
        sum_d = rsgi_pkg::SUM_MIN[47:0];
        sat_d = 1'b1;
      end else begin
        sum_d = next_sum[47:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      sum_q <= '0;
      sat_q <= 1'b0;
    end else begin
      v1_q  <= req_i.valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      sum_q <= sum_d;
      sat_q <= sat_d;
    end
  end

  assign status_o.busy = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign status_o.sat  = sat_q;
  assign sum_o         = sum_q;

endmodule

@@ design/riemann_sum_gaussian_integrator_unit.sv @@
// Top level: job sequencer, configuration registers and step computation.
//
// Channel   Direction  Handshake                 Payload
// request   in         start_i & !busy_o         start_index_i, end_index_i
// result    out        done_o, one cycle         partial_sum_o, saturated_o
// config    in         cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// Setup of a request runs the bit-serial divider to form the step and the two zone bounds;
// points are then issued only for indices with |x| < 4.
// Points enter the lookup pipeline one per cycle; it drains before the result is given.
// Reset clears the configuration to lower 0, upper 1.0, count 1; the table is constant.
// One request is handled at a time and the result cannot be stalled.
module riemann_sum_gaussian_integrator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [31:0]        start_index_i,
  input  logic [31:0]        end_index_i,
  output logic               done_o,
  output logic signed [47:0] partial_sum_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned DB = rsgi_pkg::DIV_BITS;

  rsgi_pkg::seq_state_e   state_q, state_d;
  logic signed [31:0]     lower_q, upper_q;
  logic [31:0]            count_q;
  logic [31:0]            start_q, start_d, end_q, end_d;
  logic                   diffneg_q, diffneg_d;
  logic signed [31:0]     s_q, s_d;
  logic [31:0]            st_q, st_d;
  logic                   sat_q, sat_d;
  logic signed [64:0]     prod_q, prod_d;
  logic                   nneg_q, nneg_d;
  logic                   mnonpos_q, mnonpos_d;
  logic [DB-1:0]          lo_q, lo_d;
  logic [DB-1:0]          a_q, a_d;
  logic signed [31:0]     x_q, x_d;
  logic [31:0]            rem_q, rem_d;

  logic                   div_start;
  logic [DB-1:0]          div_dividend;
  logic [31:0]            div_divisor;
  logic                   div_done;
  logic [DB-1:0]          div_quo;

  logic signed [32:0]     diff;
  logic [32:0]            diff_mag;
  logic signed [65:0]     xw;
  logic                   clip;
  logic signed [34:0]     sl, n_val, m_val;
  logic [DB-1:0]          hi, a_c, b_c;
  logic                   pipe_clear;
  rsgi_pkg::point_req_t   req;
  rsgi_pkg::pipe_status_t pstat;
  logic signed [47:0]     pipe_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= 32'sd0;
      upper_q <= 32'sd16777216;
      count_q <= 32'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rsgi_pkg::REG_LOWER: lower_q <= cfg_data_i;
        rsgi_pkg::REG_UPPER: upper_q <= cfg_data_i;
        rsgi_pkg::REG_COUNT: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rsgi_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  rsgi_point_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (pipe_clear),
    .req_i      (req),
    .step_mag_i (st_q),
    .step_neg_i (s_q[31]),
    .status_o   (pstat),
    .sum_o      (pipe_sum)
  );

  always_comb begin
    diff     = {upper_q[31], upper_q} - {lower_q[31], lower_q};
    diff_mag = diff[32] ? 33'(-diff) : diff;
    xw       = {{34{lower_q[31]}}, lower_q} + {prod_q[64], prod_q};
    clip     = (xw > 66'sd2147483647) || (xw < -66'sd2147483648);
    sl       = s_q[31] ? -{{3{lower_q[31]}}, lower_q} : {{3{lower_q[31]}}, lower_q};
    n_val    = -rsgi_pkg::ZONE_EDGE - sl;
    m_val    = rsgi_pkg::ZONE_EDGE - sl;
    hi       = mnonpos_q ? '0 : div_quo;
    a_c      = ({2'b0, start_q} > lo_q) ? {2'b0, start_q} : lo_q;
    b_c      = ({2'b0, end_q} < hi) ? {2'b0, end_q} : hi;
  end

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    end_d        = end_q;
    diffneg_d    = diffneg_q;
    s_d          = s_q;
    st_d         = st_q;
    sat_d        = sat_q;
    prod_d       = prod_q;
    nneg_d       = nneg_q;
    mnonpos_d    = mnonpos_q;
    lo_d         = lo_q;
    a_d          = a_q;
    x_d          = x_q;
    rem_d        = rem_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = st_q;
    pipe_clear   = 1'b0;
    req.valid    = 1'b0;
    req.x        = x_q;
    done_o       = 1'b0;
    case (state_q)
      rsgi_pkg::ST_IDLE: begin
        if (start_i) begin
          start_d      = start_index_i & rsgi_pkg::IDX_MASK;
          end_d        = end_index_i & rsgi_pkg::IDX_MASK;
          diffneg_d    = diff[32];
          sat_d        = 1'b0;
          pipe_clear   = 1'b1;
          div_start    = 1'b1;
          div_dividend = {1'b0, diff_mag};
          div_divisor  = (count_q == 32'd0) ? 32'd1 : count_q;
          state_d      = rsgi_pkg::ST_DIV_STEP;
        end
      end
      rsgi_pkg::ST_DIV_STEP: begin
        if (div_done) begin
          if (!diffneg_q) begin
            if (div_quo > DB'(32'h7FFF_FFFF)) begin
              s_d   = 32'sh7FFF_FFFF;
              sat_d = 1'b1;
            end else begin
              s_d = div_quo[31:0];
            end
          end else begin
            if (div_quo > DB'(32'h8000_0000)) begin
              s_d   = 32'sh8000_0000;
              sat_d = 1'b1;
            end else begin
              s_d = 32'(-div_quo[31:0]);
            end
          end
          st_d    = s_d[31] ? 32'(-s_d) : s_d;
          state_d = (start_q >= end_q) ? rsgi_pkg::ST_DONE : rsgi_pkg::ST_MUL0;
        end
      end
      rsgi_pkg::ST_MUL0: begin
        prod_d  = $signed({1'b0, start_q}) * s_q;
        state_d = rsgi_pkg::ST_MUL1;
      end
      rsgi_pkg::ST_MUL1: begin
        if (clip) sat_d = 1'b1;
        prod_d  = $signed({1'b0, 32'(end_q - 32'd1)}) * s_q;
        state_d = rsgi_pkg::ST_CHK;
      end
      rsgi_pkg::ST_CHK: begin
        if (clip) sat_d = 1'b1;
        if (s_q == 32'sd0) begin
          state_d = rsgi_pkg::ST_DONE;
        end else begin
          nneg_d       = n_val[34];
          div_start    = 1'b1;
          div_dividend = n_val[34] ? '0 : n_val[DB-1:0];
          state_d      = rsgi_pkg::ST_DIV_LO;
        end
      end
      rsgi_pkg::ST_DIV_LO: begin
        if (div_done) begin
          lo_d         = nneg_q ? '0 : div_quo + 1'b1;
          mnonpos_d    = m_val[34] || (m_val == 35'sd0);
          div_start    = 1'b1;
          div_dividend = mnonpos_d ? '0 : DB'(m_val[DB-1:0] + {2'b0, st_q} - 1'b1);
          state_d      = rsgi_pkg::ST_DIV_HI;
        end
      end
      rsgi_pkg::ST_DIV_HI: begin
        if (div_done) begin
          if (a_c >= b_c) begin
            state_d = rsgi_pkg::ST_DONE;
          end else begin
            a_d     = a_c;
            rem_d   = 32'(b_c - a_c);
            state_d = rsgi_pkg::ST_MULX;
          end
        end
      end
      rsgi_pkg::ST_MULX: begin
        prod_d  = $signed({1'b0, a_q[31:0]}) * s_q;
        state_d = rsgi_pkg::ST_LOADX;
      end
      rsgi_pkg::ST_LOADX: begin
        x_d     = lower_q + prod_q[31:0];
        state_d = rsgi_pkg::ST_RUN;
      end
      rsgi_pkg::ST_RUN: begin
        req.valid = 1'b1;
        x_d       = x_q + s_q;
        rem_d     = rem_q - 32'd1;
        if (rem_q == 32'd1) state_d = rsgi_pkg::ST_DRAIN;
      end
      rsgi_pkg::ST_DRAIN: begin
        if (!pstat.busy) state_d = rsgi_pkg::ST_DONE;
      end
      rsgi_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = rsgi_pkg::ST_IDLE;
      end
      default: state_d = rsgi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsgi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    end_q     <= end_d;
    diffneg_q <= diffneg_d;
    s_q       <= s_d;
    st_q      <= st_d;
    sat_q     <= sat_d;
    prod_q    <= prod_d;
    nneg_q    <= nneg_d;
    mnonpos_q <= mnonpos_d;
    lo_q      <= lo_d;
    a_q       <= a_d;
    x_q       <= x_d;
    rem_q     <= rem_d;
  end

  assign busy_o        = (state_q != rsgi_pkg::ST_IDLE);
  assign partial_sum_o = pipe_sum;
  assign saturated_o   = sat_q | pstat.sat;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("Result strobe outside a request.");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("Result strobe longer than one cycle.");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("Accepted request did not start.");
  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !pstat.busy) else $error("Result given while points in flight.");
`endif

endmodule

@@ tb/tb.sv @@
// Testbench of the Gaussian Riemann sum unit: queued requests with a self-checking sum predictor.
`timescale 1ns / 1ps

module tb;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_SYNC} op_e;
  typedef struct {
    op_e         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [1:0]  idx;
  } pending_op_t;
  typedef struct {
    logic [47:0] sum;
    logic        sat;
  } chunk_sum_t;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam longint MIN_STEP = 65536;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [31:0]        start_index_i;
  logic [31:0]        end_index_i;
  logic               done_o;
  logic signed [47:0] partial_sum_o;
  logic               saturated_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  pending_op_t pending_ops[$];
  chunk_sum_t  pending_sums[$];
  logic [31:0] gauss_table[rsgi_pkg::EXP_TABLE_DEPTH];
  logic [31:0] lower_q = 32'd0;
  logic [31:0] upper_q = 32'd16777216;
  logic [31:0] count_q = 32'd1;
  int unsigned errors = 0;
  int unsigned gap_cycles = 0;
  int unsigned idle_cycles = 0;
  bit          tail_phase = 1'b0;

  riemann_sum_gaussian_integrator_unit DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic void build_gauss_table();
    logic [63:0] ratio;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] rounded;
    term  = 64'd1 << 60;
    ratio = 64'd1 << 60;
    e     = 64'd1 << 60;
    for (int k = 1; k <= 24; k++) begin
      term = q60_product(term, 64'd1 << 54) / 64'(k);
      ratio = (k % 2 == 1) ? ratio - term : ratio + term;
    end
    for (int k = 0; k < rsgi_pkg::EXP_TABLE_DEPTH; k++) begin
      rounded = (e + (64'd1 << 28)) >> 29;
      gauss_table[k] = rounded[31:0];
      e = q60_product(e, ratio);
    end
  endfunction

  function automatic longint step_of(logic [31:0] lo, logic [31:0] up, logic [31:0] cnt);
    longint c;
    c = (cnt == 0) ? 64'sd1 : longint'({32'd0, cnt});
    return (longint'($signed(up)) - longint'($signed(lo))) / c;
  endfunction

  function automatic logic [63:0] gauss_of(longint x);
    logic [63:0] ax;
    logic [63:0] u;
    logic [63:0] seg;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] a;
    logic [63:0] b;
    ax   = (x < 0) ? -x : x;
    u    = ax * ax;
    seg  = (u >> 20) * rsgi_pkg::EXP_TABLE_DEPTH;
    idx  = seg >> 32;
    frac = {32'd0, seg[31:0]};
    if (idx >= rsgi_pkg::EXP_TABLE_DEPTH) return 64'd0;
    a = {32'd0, gauss_table[idx]};
    b = (idx + 1 < rsgi_pkg::EXP_TABLE_DEPTH) ? {32'd0, gauss_table[idx + 1]} : 64'd0;
    if (a < b) b = a;
    return a - (((a - b) * frac) >> 32);
  endfunction

  function automatic bit clipped(longint lo, logic [31:0] i, longint s);
    logic signed [79:0] x;
    x = 80'(lo) + $signed({48'd0, i}) * 80'(s);
    return (x > 80'sd2147483647) || (x < -80'sd2147483648);
  endfunction

  function automatic chunk_sum_t integrate_chunk(logic [31:0] first, logic [31:0] last);
    chunk_sum_t r;
    longint lo, s, st, sl, n, m, zlo, zhi, a, b, sum;
    logic [63:0] mag;
    bit sat;
    first = first & rsgi_pkg::IDX_MASK;
    last  = last & rsgi_pkg::IDX_MASK;
    lo  = longint'($signed(lower_q));
    s   = step_of(lower_q, upper_q, count_q);
    sat = 1'b0;
    sum = 0;
    if (s > 64'sd2147483647) begin s = 64'sd2147483647; sat = 1'b1; end
    if (s < -64'sd2147483648) begin s = -64'sd2147483648; sat = 1'b1; end
    if (first < last) begin
      if (clipped(lo, first, s) || clipped(lo, last - 32'd1, s)) sat = 1'b1;
      if (s != 0) begin
        sl  = (s < 0) ? -lo : lo;
        st  = (s < 0) ? -s : s;
        n   = -64'sd67108864 - sl;
        m   = 64'sd67108864 - sl;
        zlo = (n < 0) ? 0 : n / st + 1;
        zhi = (m <= 0) ? 0 : (m + st - 1) / st;
        a   = (zlo > longint'({32'd0, first})) ? zlo : longint'({32'd0, first});
        b   = (zhi < longint'({32'd0, last})) ? zhi : longint'({32'd0, last});
        for (longint i = a; i < b; i++) begin
          mag = (gauss_of(lo + i * s) * 64'(st)) >> 15;
          sum += (s < 0) ? -longint'(mag) : longint'(mag);
          if (sum > 64'sh7FFF_FFFF_FFFF) begin sum = 64'sh7FFF_FFFF_FFFF; sat = 1'b1; break; end
          if (sum < -64'sh8000_0000_0000) begin
            sum = -64'sh8000_0000_0000;
            sat = 1'b1;
            break;
          end
        end
      end
    end
    r.sum = sum[47:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic add_req(logic [31:0] a, logic [31:0] b);
    pending_ops.push_back('{OP_REQ, a, b, 2'd0});
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] data);
    pending_ops.push_back('{OP_CFG, data, 32'd0, idx});
  endtask

  function automatic logic [31:0] clamp_index(longint v);
    if (v < 0) return 32'd0;
    if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // Picks a setting whose step is zero or coarse enough to keep the point walk short, then queues n requests.
  task automatic random_phase(int unsigned n);
    logic [31:0] lo, up, cnt;
    longint s, st, center, w, first;
    int unsigned kind;
    do begin
      lo  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 160)) - 80)
            << 22;
      up  = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 160)) - 80)
            << 22;
      case ($urandom_range(0, 4))
        0: cnt = 32'd0;
        1: cnt = 32'd1;
        2: cnt = $urandom;
        default: cnt = $urandom_range(1, 2048);
      endcase
      s  = step_of(lo, up, cnt);
      st = (s < 0) ? -s : s;
    end while (s != 0 && st < MIN_STEP);
    add_cfg(rsgi_pkg::REG_LOWER, lo);
    add_cfg(rsgi_pkg::REG_UPPER, up);
    add_cfg(rsgi_pkg::REG_COUNT, cnt);
    if (st > 64'sd2147483647) st = 64'sd2147483648;
    center = (s == 0) ? 0 : -longint'($signed(lo)) / ((s < 0) ? -st : st);
    w = (st == 0) ? 16 : 64'sd67108864 / st + 3;
    for (int unsigned k = 0; k < n; k++) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        first = center - w - 2 + longint'($urandom_range(0, 32'(2 * w + 4)));
        add_req(clamp_index(first),
                clamp_index(first + longint'($urandom_range(0, 32'(2 * w + 4)))));
      end else if (kind < 17) begin
        add_req($urandom, $urandom);
      end else begin
        first = longint'($urandom);
        add_req(first[31:0], first[31:0] - $urandom_range(0, 3));
      end
      if (k == n / 2 && $urandom_range(0, 1) == 1) pending_ops.push_back('{OP_SYNC, 0, 0, 0});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit fired;
    bit nxt_start;
    bit nxt_cfg;
    if (!rst_ni) begin
      start_i       <= 1'b0;
      start_index_i <= '0;
      end_index_i   <= '0;
      cfg_valid_i   <= 1'b0;
      cfg_index_i   <= '0;
      cfg_data_i    <= '0;
    end else begin
      fired = 1'b0;
      if (start_i && !busy_o) begin
        pending_sums.push_back(integrate_chunk(start_index_i, end_index_i));
        fired = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rsgi_pkg::REG_LOWER: lower_q = cfg_data_i;
          rsgi_pkg::REG_UPPER: upper_q = cfg_data_i;
          rsgi_pkg::REG_COUNT: count_q = cfg_data_i;
          default: ;
        endcase
        fired = 1'b1;
      end
      if (!(start_i && busy_o) && !(cfg_valid_i && !cfg_ready_o)) begin
        nxt_start = 1'b0;
        nxt_cfg   = 1'b0;
        if (fired && !tail_phase && $urandom_range(0, 3) == 0) begin
          gap_cycles = $urandom_range(1, 13);
        end else if (gap_cycles > 0) begin
          gap_cycles--;
        end else if (pending_ops.size() > 0) begin
          case (pending_ops[0].op)
            OP_REQ: begin
              start_index_i <= pending_ops[0].a;
              end_index_i   <= pending_ops[0].b;
              nxt_start = 1'b1;
              void'(pending_ops.pop_front());
            end
            OP_CFG: begin
              if (!fired && !busy_o && pending_sums.size() == 0) begin
                cfg_index_i <= pending_ops[0].idx;
                cfg_data_i  <= pending_ops[0].a;
                nxt_cfg = 1'b1;
                void'(pending_ops.pop_front());
              end
            end
            default: begin
              if (!fired && pending_sums.size() == 0) void'(pending_ops.pop_front());
            end
          endcase
        end
        start_i     <= nxt_start;
        cfg_valid_i <= nxt_cfg;
      end
      tail_phase = (pending_ops.size() < 30);
    end
  end

  always @(posedge clk_i) begin
    chunk_sum_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("result with no request waiting", partial_sum_o, '0);
        end else begin
          want = pending_sums.pop_front();
          if (partial_sum_o !== want.sum) report_mismatch("partial_sum", partial_sum_o, want.sum);
          if (saturated_o !== want.sat) report_mismatch("saturated", 48'(saturated_o), 48'(want.sat));
        end
      end
      if (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("riemann_sum_gaussian_integrator_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    build_gauss_table();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(32'd0, 32'd1);
    add_req(32'd0, 32'd4);
    add_req(32'd0, 32'd0);
    add_req(32'd5, 32'd2);
    add_req(32'd0, 32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cfg(rsgi_pkg::REG_LOWER, 32'h8000_0000);
    add_cfg(rsgi_pkg::REG_UPPER, 32'h7FFF_FFFF);
    add_req(32'd0, 32'd2);
    add_req(32'd1, 32'd3);
    add_cfg(rsgi_pkg::REG_LOWER, 32'd0);
    add_cfg(rsgi_pkg::REG_UPPER, 32'h8000_0000);
    add_req(32'd0, 32'd1);
    add_req(32'd0, 32'd3);
    add_cfg(rsgi_pkg::REG_LOWER, 32'hFC00_0000);
    add_cfg(rsgi_pkg::REG_UPPER, 32'h0400_0000);
    add_cfg(rsgi_pkg::REG_COUNT, 32'd0);
    add_req(32'd0, 32'd1);
    add_cfg(rsgi_pkg::REG_COUNT, 32'd1024);
    add_req(32'd0, 32'd1024);
    add_req(32'd0, 32'hFFFF_FFFF);
    add_req(32'd1000, 32'd1100);
    add_cfg(rsgi_pkg::REG_COUNT, 32'hFFFF_FFFF);
    add_req(32'd0, 32'd100);
    add_req(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    for (int p = 0; p < 6; p++) random_phase(20);

    do @(posedge clk_i);
    while (pending_ops.size() != 0 || pending_sums.size() != 0 || start_i || cfg_valid_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_sums.size() == 0)
      $display("riemann_sum_gaussian_integrator_unit verification clean");
    else
      $display("riemann_sum_gaussian_integrator_unit verification failed");
    $finish;
  end

endmodule
